### rtl/core/rrfd_pkg.sv
// ----------------------------------------------------------------------------
// rrfd_pkg
// shared types and constants of the reader reply frame deframer
// ----------------------------------------------------------------------------
`default_nettype none

package rrfd_pkg;

    localparam logic [7:0] SYNC_BYTE      = 8'hD9;
    localparam logic [7:0] READ_CMD       = 8'h2B;
    localparam logic [7:0] STOP_FLAGS     = 8'h02;
    localparam logic [7:0] TAG_BASE_LEN   = 8'd28;
    localparam logic [7:0] STOP_FRAME_LEN = 8'd13;
    localparam logic [7:0] TID_CODE       = 8'd6;
    localparam logic [3:0] TID_BYTES      = 4'd12;
    localparam logic [7:0] LEN_MIN        = 8'd4;
    localparam logic [7:0] LEN_CAP        = 8'd253;
    localparam logic [7:0] MAX_LEN_RESET  = 8'd222;

    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_TIMEOUT = 1'b1;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_LEN  = 2'd1,
        PH_BODY = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        KIND_TAG      = 3'd0,
        KIND_EMPTY    = 3'd1,
        KIND_STOPPED  = 3'd2,
        KIND_SHORT    = 3'd3,
        KIND_OTHER    = 3'd4,
        KIND_CSUM_ERR = 3'd5
    } t_kind;

    typedef struct packed {
        logic       sum_ok;
        logic [7:0] flen;
        logic [7:0] cmd;
        logic [7:0] flags;
        logic [7:0] prev;
    } t_frame;

endpackage

`default_nettype wire

### rtl/core/rrfd_framer.sv
// ----------------------------------------------------------------------------
// rrfd_framer
// input register, sync/length/checksum tracking and the frame record register
// ----------------------------------------------------------------------------
`default_nettype none

module rrfd_framer
    import rrfd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_wr_en,
    input  wire logic [7:0] i_cfg_wr_data,
    input  wire logic       i_in_valid,
    output      logic       o_in_stall,
    input  wire logic       i_opcode,
    input  wire logic [7:0] i_rx_byte,
    output      logic       o_frm_valid,
    output      t_frame     o_frm,
    input  wire logic       i_frm_ready
);

    logic       r_in_valid;
    logic       r_in_op;
    logic [7:0] r_in_byte;
    logic [7:0] r_max_len;

    t_phase     r_phase, n_phase;
    logic [7:0] r_exp_len, n_exp_len;
    logic [7:0] r_count, n_count;
    logic [7:0] r_sum, n_sum;
    logic [7:0] r_cmd, n_cmd;
    logic [7:0] r_flags, n_flags;
    logic [7:0] r_prev, n_prev;

    logic       r_frm_valid, n_frm_valid;
    t_frame     r_frm, n_frm;

    logic       frm_free;
    logic       step;
    logic [7:0] limit;
    logic       len_bad;
    logic [7:0] count_inc;
    logic       last_byte;
    logic [7:0] sum_inc;

    assign frm_free   = !r_frm_valid || i_frm_ready;
    assign step       = r_in_valid && frm_free;
    assign o_in_stall = r_in_valid && !frm_free;

    assign limit     = (r_max_len > LEN_CAP) ? LEN_CAP : r_max_len;
    assign len_bad   = (r_in_byte < LEN_MIN) || (r_in_byte > limit);
    assign count_inc = r_count + 8'd1;
    assign last_byte = (count_inc == r_exp_len);
    assign sum_inc   = r_sum + r_in_byte;

    // next state
    always_comb begin
        n_phase = r_phase;
        if (step) begin
            if (r_in_op == OP_TIMEOUT) begin
                n_phase = PH_HUNT;
            end else begin
                unique case (r_phase)
                    PH_HUNT: n_phase = (r_in_byte == SYNC_BYTE) ? PH_LEN : PH_HUNT;
                    PH_LEN:  n_phase = len_bad ? PH_HUNT : PH_BODY;
                    PH_BODY: n_phase = last_byte ? PH_HUNT : PH_BODY;
                    default: n_phase = (r_in_byte == SYNC_BYTE) ? PH_LEN : PH_HUNT;
                endcase
            end
        end
    end

    // datapath and frame record
    always_comb begin
        n_exp_len   = r_exp_len;
        n_count     = r_count;
        n_sum       = r_sum;
        n_cmd       = r_cmd;
        n_flags     = r_flags;
        n_prev      = r_prev;
        n_frm_valid = frm_free ? 1'b0 : r_frm_valid;
        n_frm       = r_frm;
        if (step && r_in_op == OP_BYTE) begin
            unique case (r_phase)
                PH_LEN: begin
                    if (!len_bad) begin
                        n_exp_len = r_in_byte;
                        n_count   = '0;
                        n_sum     = sum_inc;
                    end
                end
                PH_BODY: begin
                    n_count = count_inc;
                    if (r_count == 8'd3) begin
                        n_flags = r_in_byte;
                    end
                    if (!last_byte) begin
                        if (r_count == 8'd2) begin
                            n_cmd = r_in_byte;
                        end
                        n_sum  = sum_inc;
                        n_prev = r_in_byte;
                    end else begin
                        n_frm_valid  = 1'b1;
                        n_frm.sum_ok = (sum_inc == 8'd0);
                        n_frm.flen   = r_exp_len + 8'd2;
                        n_frm.cmd    = r_cmd;
                        n_frm.flags  = (r_count == 8'd3) ? r_in_byte : r_flags;
                        n_frm.prev   = r_prev;
                    end
                end
                default: begin
                    if (r_in_byte == SYNC_BYTE) begin
                        n_sum   = SYNC_BYTE;
                        n_cmd   = '0;
                        n_flags = '0;
                        n_prev  = '0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_max_len   <= MAX_LEN_RESET;
            r_phase     <= PH_HUNT;
            r_frm_valid <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (i_cfg_wr_en) begin
                r_max_len <= i_cfg_wr_data;
            end
            r_phase     <= n_phase;
            r_frm_valid <= n_frm_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_op   <= i_opcode;
            r_in_byte <= i_rx_byte;
        end
        r_exp_len <= n_exp_len;
        r_count   <= n_count;
        r_sum     <= n_sum;
        r_cmd     <= n_cmd;
        r_flags   <= n_flags;
        r_prev    <= n_prev;
        r_frm     <= n_frm;
    end

    assign o_frm_valid = r_frm_valid;
    assign o_frm       = r_frm;

`ifndef NO_ASSERTIONS
    a_body_len_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_BODY) |-> (r_exp_len >= LEN_MIN) && (r_exp_len <= LEN_CAP))
        else $error("frame length out of range while collecting");

    a_body_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_BODY) |-> (r_count < r_exp_len))
        else $error("byte count past frame end");

    a_frm_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_frm_valid && !i_frm_ready) |=> (r_frm_valid && $stable(r_frm)))
        else $error("stalled frame record changed");
`endif

endmodule

`default_nettype wire

### rtl/core/rrfd_classify.sv
// ----------------------------------------------------------------------------
// rrfd_classify
// sorts a finished frame into its reply kind and holds the result register
// ----------------------------------------------------------------------------
`default_nettype none

module rrfd_classify
    import rrfd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_frm_valid,
    input  wire t_frame     i_frm,
    output      logic       o_frm_ready,
    output      logic       o_out_valid,
    input  wire logic       i_out_stall,
    output      logic [2:0] o_kind,
    output      logic [7:0] o_frame_length,
    output      logic [7:0] o_command_code,
    output      logic [7:0] o_status_flags,
    output      logic [7:0] o_epc_length,
    output      logic [3:0] o_tid_length
);

    logic       r_out_valid;
    t_kind      r_kind, n_kind;
    logic [7:0] r_flen;
    logic [7:0] r_cmd;
    logic [7:0] r_flags;
    logic [7:0] r_epc, n_epc;
    logic [3:0] r_tid, n_tid;

    logic       out_free;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_frm_ready = out_free;

    always_comb begin
        n_kind = KIND_TAG;
        n_epc  = '0;
        n_tid  = '0;
        priority if (!i_frm.sum_ok) begin
            n_kind = KIND_CSUM_ERR;
        end else if (i_frm.flen < TAG_BASE_LEN) begin
            n_kind = (i_frm.flen == STOP_FRAME_LEN && i_frm.flags == STOP_FLAGS)
                     ? KIND_STOPPED : KIND_SHORT;
        end else if (i_frm.cmd != READ_CMD) begin
            n_kind = KIND_OTHER;
        end else if (i_frm.flen == TAG_BASE_LEN && i_frm.prev == 8'd0) begin
            n_kind = KIND_EMPTY;
        end else begin
            n_kind = KIND_TAG;
            n_epc  = i_frm.flen - TAG_BASE_LEN;
            n_tid  = (i_frm.prev == TID_CODE) ? TID_BYTES : 4'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= i_frm_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_frm_valid && out_free) begin
            r_kind  <= n_kind;
            r_flen  <= i_frm.flen;
            r_cmd   <= i_frm.cmd;
            r_flags <= i_frm.flags;
            r_epc   <= n_epc;
            r_tid   <= n_tid;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_kind;
    assign o_frame_length = r_flen;
    assign o_command_code = r_cmd;
    assign o_status_flags = r_flags;
    assign o_epc_length   = r_epc;
    assign o_tid_length   = r_tid;

`ifndef NO_ASSERTIONS
    a_lengths_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_kind != KIND_TAG) |-> (r_epc == 8'd0) && (r_tid == 4'd0))
        else $error("tag lengths set on a non tag result");

    a_tag_long: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_kind == KIND_TAG) |->
            (r_flen >= TAG_BASE_LEN) && (r_cmd == READ_CMD)
            && (r_epc == r_flen - TAG_BASE_LEN))
        else $error("tag read result inconsistent");

    a_tid_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_tid == 4'd0) || (r_tid == TID_BYTES))
        else $error("bad tid length");
`endif

endmodule

`default_nettype wire

### rtl/core/rfid_reply_frame_deframer.sv
// ----------------------------------------------------------------------------
// rfid_reply_frame_deframer
// finds sync/length framed reader replies in a byte stream, checks the
// checksum and classifies each complete frame
// ----------------------------------------------------------------------------
// channel  | handshake                  | payload
// in       | i_in_valid / o_in_stall    | i_opcode, i_rx_byte
// out      | o_out_valid / i_out_stall  | o_kind .. o_tid_length
// cfg      | i_cfg_wr_en                | i_cfg_wr_data (max length byte)
//
// one word per cycle while o_in_stall is low; the frame result of a checksum
// word passes the input register, frame record register and result register
// sync reset clears the handshake state and the phase, sets max length to 222
// a stalled result holds back the frame record and then the input register
// ----------------------------------------------------------------------------
`default_nettype none

module rfid_reply_frame_deframer
    import rrfd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_wr_en,
    input  wire logic [7:0] i_cfg_wr_data,
    input  wire logic       i_in_valid,
    output      logic       o_in_stall,
    input  wire logic       i_opcode,
    input  wire logic [7:0] i_rx_byte,
    output      logic       o_out_valid,
    input  wire logic       i_out_stall,
    output      logic [2:0] o_kind,
    output      logic [7:0] o_frame_length,
    output      logic [7:0] o_command_code,
    output      logic [7:0] o_status_flags,
    output      logic [7:0] o_epc_length,
    output      logic [3:0] o_tid_length
);

    logic   frm_valid;
    t_frame frm;
    logic   frm_ready;

    rrfd_framer u_framer (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_opcode      (i_opcode),
        .i_rx_byte     (i_rx_byte),
        .o_frm_valid   (frm_valid),
        .o_frm         (frm),
        .i_frm_ready   (frm_ready)
    );

    rrfd_classify u_classify (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_frm_valid    (frm_valid),
        .i_frm          (frm),
        .o_frm_ready    (frm_ready),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_kind         (o_kind),
        .o_frame_length (o_frame_length),
        .o_command_code (o_command_code),
        .o_status_flags (o_status_flags),
        .o_epc_length   (o_epc_length),
        .o_tid_length   (o_tid_length)
    );

endmodule

`default_nettype wire
